@@ hw/rtl/tkms_pkg.sv @@
// Shared constants, types and controller/datapath interface for the top-k sparsifier.
package tkms_pkg;

    localparam int MAX_LEN    = 64;
    localparam int ADDR_W     = $clog2(MAX_LEN);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int SAMPLE_W   = 32;
    localparam int IDX_W      = 6;
    localparam int FRAC_W     = 17;
    localparam int FRAC_SHIFT = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [FRAC_W-1:0]   FRAC_ONE      = 17'h1_0000;
    localparam logic [SAMPLE_W-1:0] ONE_Q16       = 32'h0001_0000;
    localparam logic [SAMPLE_W-1:0] MINUS_ONE_Q16 = 32'hFFFF_0000;

    localparam logic [CFG_IDX_W-1:0] REG_KEEP_FRACTION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_MODE     = 1'b1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_I,
        S_CAP_I,
        S_SWEEP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_elem;
        logic cap_elem;
        logic sweep;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic load_close;
        logic sweep_done;
        logic elem_last;
        logic out_free;
    } t_dp_status;

endpackage

@@ hw/rtl/tkms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tkms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/tkms_ctrl.sv @@
// Controller state machine: load, per-element rank sweep, emit.
module tkms_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_sample_valid,
    output logic                 o_sample_ready,
    input  tkms_pkg::t_dp_status i_status,
    output tkms_pkg::t_dp_cmd    o_cmd
);

    tkms_pkg::t_state r_state;
    tkms_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tkms_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tkms_pkg::S_LOAD: begin
                if (i_sample_valid && i_status.load_close) begin
                    n_state = tkms_pkg::S_RD_I;
                end
            end
            tkms_pkg::S_RD_I: begin
                n_state = tkms_pkg::S_CAP_I;
            end
            tkms_pkg::S_CAP_I: begin
                n_state = tkms_pkg::S_SWEEP;
            end
            tkms_pkg::S_SWEEP: begin
                if (i_status.sweep_done) begin
                    n_state = tkms_pkg::S_EMIT;
                end
            end
            tkms_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.elem_last ? tkms_pkg::S_LOAD : tkms_pkg::S_RD_I;
                end
            end
            default: begin
                n_state = tkms_pkg::S_LOAD;
            end
        endcase
    end

    always_comb begin
        o_sample_ready = 1'b0;
        o_cmd          = '0;
        case (r_state)
            tkms_pkg::S_LOAD: begin
                o_sample_ready = 1'b1;
                o_cmd.load     = i_sample_valid;
            end
            tkms_pkg::S_RD_I: begin
                o_cmd.rd_elem = 1'b1;
            end
            tkms_pkg::S_CAP_I: begin
                o_cmd.cap_elem = 1'b1;
            end
            tkms_pkg::S_SWEEP: begin
                o_cmd.sweep = 1'b1;
            end
            tkms_pkg::S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/tkms_dp.sv @@
// Datapath: sample store, config registers, rank counter and output register.
module tkms_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tkms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tkms_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [tkms_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last_in,
    input  tkms_pkg::t_dp_cmd                   i_cmd,
    output tkms_pkg::t_dp_status                o_status,
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    output logic signed [tkms_pkg::SAMPLE_W-1:0] o_result_value,
    output logic [tkms_pkg::IDX_W-1:0]          o_element_index,
    output logic                                o_last_out
);

    logic [tkms_pkg::FRAC_W-1:0]   r_frac;
    logic                          r_mode;
    logic [tkms_pkg::ADDR_W-1:0]   r_count;
    logic [tkms_pkg::LEN_W-1:0]    r_len;
    logic [tkms_pkg::LEN_W-1:0]    r_keep;
    logic [tkms_pkg::ADDR_W-1:0]   r_i;
    logic [tkms_pkg::ADDR_W-1:0]   r_j;
    logic [tkms_pkg::SAMPLE_W-1:0] r_vi;
    logic [tkms_pkg::SAMPLE_W-1:0] r_mi;
    logic [tkms_pkg::LEN_W-1:0]    r_rank;

    logic                          r_out_valid;
    logic [tkms_pkg::SAMPLE_W-1:0] r_out_value;
    logic [tkms_pkg::IDX_W-1:0]    r_out_index;
    logic                          r_out_last;

    logic [tkms_pkg::SAMPLE_W-1:0] rd_data;
    logic [tkms_pkg::SAMPLE_W-1:0] mag_j;
    logic [tkms_pkg::SAMPLE_W-1:0] mag_rd;
    logic [tkms_pkg::ADDR_W-1:0]   rd_addr;
    logic                          rd_en;
    logic [tkms_pkg::FRAC_W-1:0]   frac_sat;
    logic [tkms_pkg::LEN_W-1:0]    n_len;
    logic [tkms_pkg::LEN_W+tkms_pkg::FRAC_W-1:0] keep_prod;
    logic                          hit;
    logic [tkms_pkg::SAMPLE_W-1:0] res;
    logic                          out_free;

    tkms_ram #(
        .WIDTH (tkms_pkg::SAMPLE_W),
        .DEPTH (tkms_pkg::MAX_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (i_cmd.load),
        .i_wr_addr (r_count),
        .i_wr_data (i_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Magnitude as unsigned: the most negative sample maps to 2^31.
    assign mag_rd = rd_data[tkms_pkg::SAMPLE_W-1] ? (~rd_data + 1'b1) : rd_data;
    assign mag_j  = mag_rd;

    assign frac_sat  = (r_frac > tkms_pkg::FRAC_ONE) ? tkms_pkg::FRAC_ONE : r_frac;
    assign n_len     = tkms_pkg::LEN_W'(r_count) + 1'b1;
    assign keep_prod = n_len * frac_sat;

    assign o_status.load_close = i_last_in || (r_count == tkms_pkg::ADDR_W'(tkms_pkg::MAX_LEN - 1));
    assign o_status.sweep_done = (tkms_pkg::LEN_W'(r_j) + 1'b1) == r_len;
    assign o_status.elem_last  = (tkms_pkg::LEN_W'(r_i) + 1'b1) == r_len;
    assign o_status.out_free   = out_free;

    assign out_free = !r_out_valid || i_result_ready;

    always_comb begin
        rd_en   = i_cmd.rd_elem || i_cmd.cap_elem || (i_cmd.sweep && !o_status.sweep_done);
        rd_addr = r_j + 1'b1;
        if (i_cmd.rd_elem) begin
            rd_addr = r_i;
        end else if (i_cmd.cap_elem) begin
            rd_addr = '0;
        end
    end

    assign hit = (mag_j > r_mi) || ((mag_j == r_mi) && (r_j < r_i));

    always_comb begin
        res = '0;
        if (r_rank < r_keep) begin
            if (r_mode) begin
                res = r_vi[tkms_pkg::SAMPLE_W-1] ? tkms_pkg::MINUS_ONE_Q16 : tkms_pkg::ONE_Q16;
            end else begin
                res = r_vi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac      <= '0;
            r_mode      <= 1'b0;
            r_count     <= '0;
            r_len       <= '0;
            r_keep      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tkms_pkg::REG_KEEP_FRACTION: r_frac <= i_cfg_data;
                    tkms_pkg::REG_KEEP_MODE:     r_mode <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (i_cmd.load) begin
                if (o_status.load_close) begin
                    r_count <= '0;
                    r_len   <= n_len;
                    r_keep  <= tkms_pkg::LEN_W'(keep_prod >> tkms_pkg::FRAC_SHIFT);
                    r_i     <= '0;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end

            if (i_cmd.cap_elem) begin
                r_j    <= '0;
                r_rank <= '0;
            end

            if (i_cmd.sweep) begin
                r_rank <= r_rank + tkms_pkg::LEN_W'(hit);
                if (!o_status.sweep_done) begin
                    r_j <= r_j + 1'b1;
                end
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (!o_status.elem_last) begin
                    r_i <= r_i + 1'b1;
                end
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_elem) begin
            r_vi <= rd_data;
            r_mi <= mag_rd;
        end
        if (i_cmd.emit) begin
            r_out_value <= res;
            r_out_index <= tkms_pkg::IDX_W'(r_i);
            r_out_last  <= o_status.elem_last;
        end
    end

    assign o_result_valid  = r_out_valid;
    assign o_result_value  = r_out_value;
    assign o_element_index = r_out_index;
    assign o_last_out      = r_out_last;

endmodule

@@ hw/rtl/top_k_magnitude_sparsifier.sv @@
// Top level of the top-k magnitude sparsifier: controller plus datapath.
// Throughput: one input word per cycle while loading; after the closing word each element
// is read, captured, rank-swept over every stored word through the single store read port
// and emitted, the emit waiting while the output register is full. No new input word is
// taken until the last element of the vector is emitted.
// Reset (synchronous, active low) clears the state machine, counters, config registers and
// output valid; the sample store holds no reset value and is only read where written.
module top_k_magnitude_sparsifier (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [tkms_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tkms_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input words
    input  logic                                 i_sample_valid,
    output logic                                 o_sample_ready,
    input  logic signed [tkms_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_last_in,
    // result words
    output logic                                 o_result_valid,
    input  logic                                 i_result_ready,
    output logic signed [tkms_pkg::SAMPLE_W-1:0] o_result_value,
    output logic [tkms_pkg::IDX_W-1:0]           o_element_index,
    output logic                                 o_last_out
);

    // Commands flow controller to datapath; status flows back.
    tkms_pkg::t_dp_cmd    cmd;
    tkms_pkg::t_dp_status status;

    // Sequence the load, the per-element rank sweep and the emit of each word.
    tkms_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    // Hold samples, count rank against every stored magnitude, register the result word.
    tkms_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample        (i_sample),
        .i_last_in       (i_last_in),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_result_valid  (o_result_valid),
        .i_result_ready  (i_result_ready),
        .o_result_value  (o_result_value),
        .o_element_index (o_element_index),
        .o_last_out      (o_last_out)
    );

endmodule
